@@ sv/heightmap_five_point_smoothing_top_macros.svh @@
// Assertion macros shared by the smoothing block.
`ifndef HEIGHTMAP_FIVE_POINT_SMOOTHING_TOP_MACROS_SVH
`define HEIGHTMAP_FIVE_POINT_SMOOTHING_TOP_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define HMS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hms: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define HMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hms: next-cycle check failed");

`endif

@@ sv/hms_pkg.sv @@
// Shared types and constants of the five-point height map smoothing block.
`default_nettype none
package hms_pkg;

  // Field widths
  localparam int SAMPLE_W = 8;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 10;
  localparam int ROW_W    = 10;
  // Sum of three bytes
  localparam int PSUM_W   = 10;
  // Sum of five 8.8 terms
  localparam int SUM_W    = 19;
  localparam int PROD_W   = 2 * SUM_W;

  // Divide by five: multiply by ceil(2^21 / 5) and shift, exact below 699050
  localparam logic [SUM_W-1:0] DIV5_MUL   = 19'd419431;
  localparam int               DIV5_SHIFT = 21;

  // Default row store depth
  localparam int MAX_WIDTH_DEF = 512;

  // Request queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Register reset values and lower dimension bound
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd256;
  localparam logic [CFG_W-1:0] MIN_DIM      = 10'd2;

  // Classification of one request
  typedef struct packed {
    logic pass;  // row 1 or column 0: original value passes through
    logic last;  // final pixel of the image
  } hms_flags_t;

  localparam int FLAGS_W = $bits(hms_flags_t);

endpackage
`default_nettype wire

@@ sv/hms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port: data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/hms_front.sv @@
// Front end: configuration, raster counters, original row store and request classification.
`default_nettype none
module hms_front
  import hms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = CW + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [SAMPLE_W-1:0]  sample_i,
  output logic                      req_valid_o,
  input  wire logic                 req_ready_i,
  output logic      [CW-1:0]        req_col_o,
  output logic      [PSUM_W-1:0]    req_psum_o,
  output hms_flags_t                req_flags_o
);

  logic [CFG_W-1:0]    width_q, height_q;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [CW-1:0]       col_q, col_d;

  logic [CFG_W-1:0]    w_lo;
  logic [WW-1:0]       w_eff;
  logic [ROW_W-1:0]    h_eff;
  logic [WW-1:0]       col_next;
  logic                right_ok;
  logic [SAMPLE_W-1:0] s_eff;
  logic [CW-1:0]       rd_addr;
  logic                accept;
  logic [SAMPLE_W-1:0] orig_rdata;

  logic                f1_valid_q;
  logic [SAMPLE_W-1:0] f1_s_q, f1_self_q;
  logic                f1_right_ok_q;
  logic [CW-1:0]       f1_col_q;
  hms_flags_t          f1_flags_q;
  hms_flags_t          flags_d;
  logic [SAMPLE_W-1:0] right_val;

  // Clamp the frame dimensions
  always_comb begin
    w_lo = (width_q < MIN_DIM) ? MIN_DIM : width_q;
    if (32'(w_lo) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_lo);
    end
    h_eff = (height_q < MIN_DIM) ? ROW_W'(MIN_DIM) : ROW_W'(height_q);
  end

  // Classify the incoming request
  always_comb begin
    col_next      = {1'b0, col_q} + WW'(1);
    right_ok      = col_next < w_eff;
    s_eff         = (row_q >= h_eff) ? '0 : sample_i;
    rd_addr       = right_ok ? col_next[CW-1:0] : '0;
    flags_d.pass  = (row_q == ROW_W'(1)) || (col_q == '0);
    flags_d.last  = (row_q == h_eff) && !right_ok;
    if (right_ok) begin
      col_d = col_next[CW-1:0];
      row_d = row_q;
    end else begin
      col_d = '0;
      row_d = (row_q == h_eff) ? '0 : row_q + ROW_W'(1);
    end
  end

  assign in_ready_o = !f1_valid_q || req_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Original samples of the row above; read one column ahead
  hms_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WIDTH)
  ) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (s_eff),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (orig_rdata)
  );

  // Configuration registers and raster counters; a write to either register restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      row_q    <= '0;
      col_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i;
          row_q   <= '0;
          col_q   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i;
          row_q    <= '0;
          col_q    <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Hold the classified request until the queue takes it; drop the first row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (accept && (row_q != '0)) begin
      f1_valid_q <= 1'b1;
    end else if (req_ready_i) begin
      f1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (row_q != '0)) begin
      f1_s_q        <= s_eff;
      f1_self_q     <= orig_rdata;
      f1_right_ok_q <= right_ok;
      f1_col_q      <= col_q;
      f1_flags_q    <= flags_d;
    end
  end

  // Form the partial sum of the three original terms; pass requests carry the original value alone
  always_comb begin
    right_val   = f1_right_ok_q ? orig_rdata : '0;
    req_valid_o = f1_valid_q;
    req_col_o   = f1_col_q;
    req_flags_o = f1_flags_q;
    if (f1_flags_q.pass) begin
      req_psum_o = PSUM_W'(f1_self_q);
    end else begin
      req_psum_o = PSUM_W'(f1_self_q) + PSUM_W'(right_val) + PSUM_W'(f1_s_q);
    end
  end

endmodule
`default_nettype wire

@@ sv/hms_queue.sv @@
// Short request queue that decouples the front end from the back end.
`default_nettype none
module hms_queue
  import hms_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output logic      [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0]  mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != Q_CNT_W'(Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/hms_back.sv @@
// Back end: smoothed row store, five-point mean and output register.
`default_nettype none
module hms_back
  import hms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire logic [CW-1:0]       req_col_i,
  input  wire logic [PSUM_W-1:0]   req_psum_i,
  input  wire hms_flags_t          req_flags_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [HEIGHT_W-1:0] smoothed_height_o,
  output logic                     last_of_frame_o
);

  logic                b1_valid_q;
  logic [CW-1:0]       b1_col_q;
  logic [PSUM_W-1:0]   b1_psum_q;
  hms_flags_t          b1_flags_q;
  logic                b1_adv, pop;

  logic [HEIGHT_W-1:0] upper;
  logic [HEIGHT_W-1:0] left_q;
  logic [SUM_W-1:0]    sum;
  logic [PROD_W-1:0]   prod;
  logic [HEIGHT_W-1:0] val;

  logic                out_valid_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                last_q;

  assign b1_adv      = b1_valid_q && (!out_valid_q || out_ready_i);
  assign req_ready_o = !b1_valid_q || b1_adv;
  assign pop         = req_valid_i && req_ready_o;

  // Smoothed values of the row above; read on pop, written as the result leaves
  hms_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (MAX_WIDTH)
  ) u_smooth_ram (
    .clk_i   (clk_i),
    .we_i    (b1_adv),
    .waddr_i (b1_col_q),
    .wdata_i (val),
    .re_i    (pop),
    .raddr_i (req_col_i),
    .rdata_o (upper)
  );

  // Mean of five: add the smoothed terms, divide by five via reciprocal; pass keeps the original value
  always_comb begin
    sum  = SUM_W'({b1_psum_q, 8'h00}) + SUM_W'(upper) + SUM_W'(left_q);
    prod = PROD_W'(sum) * PROD_W'(DIV5_MUL);
    if (b1_flags_q.pass) begin
      val = {b1_psum_q[SAMPLE_W-1:0], 8'h00};
    end else begin
      val = prod[DIV5_SHIFT +: HEIGHT_W];
    end
  end

  // Hold the request while the smoothed value is read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (pop) begin
      b1_valid_q <= 1'b1;
    end else if (b1_adv) begin
      b1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_col_q   <= req_col_i;
      b1_psum_q  <= req_psum_i;
      b1_flags_q <= req_flags_i;
    end
  end

  // Keep the left neighbour and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (b1_adv) begin
      left_q      <= val;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_adv) begin
      height_q <= val;
      last_q   <= b1_flags_q.last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign smoothed_height_o = height_q;
  assign last_of_frame_o   = last_q;

endmodule
`default_nettype wire

@@ sv/heightmap_five_point_smoothing_top.sv @@
// Top level of the five-point height map smoothing block.
//
// Usage: write image_width (index 0) and image_height (index 1) on the cfg port
// while idle; a write to either register restarts the frame at row 0, column 0.
// Then stream one height byte per request on the input channel in raster order:
// image_height rows followed by one flush row whose samples are ignored.
// The input request at (row r, column c) produces the result for (r-1, c);
// requests of the first row produce none. last_of_frame marks the final pixel.
// A request passes the front stage, the queue, the back stage and the output register.
// Throughput: one request per cycle while out_ready_i stays high, set by the single
// add-and-divide stage that feeds the left neighbour back to the next pixel.
// Row stores are not cleared at reset; reset restores the default 256 x 256
// frame and empties the pipeline, and the block accepts requests at once.
// When the receiver stalls, the output register, the back stage, the two-entry
// queue and the front stage fill up, then in_ready_o drops; nothing is lost.
`default_nettype none
`include "heightmap_five_point_smoothing_top_macros.svh"
module heightmap_five_point_smoothing_top
  import hms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [SAMPLE_W-1:0]  sample_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [HEIGHT_W-1:0]  smoothed_height_o,
  output logic                      last_of_frame_o
);

  localparam int QDW = CW + PSUM_W + FLAGS_W;

  logic              req_valid, req_ready;
  logic [CW-1:0]     req_col;
  logic [PSUM_W-1:0] req_psum;
  hms_flags_t        req_flags;

  logic              q_valid, q_ready;
  logic [QDW-1:0]    q_data;
  logic [CW-1:0]     q_col;
  logic [PSUM_W-1:0] q_psum;
  hms_flags_t        q_flags;

  hms_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_col_o   (req_col),
    .req_psum_o  (req_psum),
    .req_flags_o (req_flags)
  );

  hms_queue #(
    .DATA_W (QDW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (req_valid),
    .push_ready_o (req_ready),
    .push_data_i  ({req_col, req_psum, req_flags}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign {q_col, q_psum, q_flags} = q_data;

  hms_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (q_valid),
    .req_ready_o       (q_ready),
    .req_col_i         (q_col),
    .req_psum_i        (q_psum),
    .req_flags_i       (q_flags),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .smoothed_height_o (smoothed_height_o),
    .last_of_frame_o   (last_of_frame_o)
  );

  // A full queue always has a request to offer the back end
  `HMS_ASSERT_NOW(a_full_queue_nonempty, req_valid && !req_ready, q_valid)
  // The front end keeps a refused request
  `HMS_ASSERT_NEXT(a_front_holds_request, req_valid && !req_ready, req_valid)
  // Input is refused only while the front end is blocked by the queue
  `HMS_ASSERT_NOW(a_stall_from_queue, !in_ready_o, req_valid && !req_ready)

endmodule
`default_nettype wire
